// ===== rtl/brce_pkg.sv =====
// ----------------------------------------------------------------------------
// brce_pkg: shared definitions of the binary rANS context encoder
// Holds the sequencer state type, the operation codes and the reset values.
// ----------------------------------------------------------------------------
package brce_pkg;

  // Default precision of the probability in bits.
  localparam int PREC_BITS_DEFAULT = 16;

  // Width of one code stream word and of the coder state.
  localparam int WORD_BITS  = 16;
  localparam int STATE_BITS = 32;

  // Coder state after reset and after a flush.
  localparam logic [STATE_BITS-1:0] STATE_RESET = 32'h0001_0000;

  // Reset value of the probability register.
  localparam logic [15:0] PROB_RESET = 16'd32768;

  // Operation codes of an input item.
  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_EMIT,
    ST_FLUSH_LO,
    ST_FLUSH_HI
  } seq_state_t;

endpackage

// ===== rtl/binary_rans_context_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// binary_rans_context_encoder_unit: binary rANS encoder with context model
// Encodes one bit per item with a context-selected probability, emits 16-bit
// renormalization words and writes out the coder state on a flush item.
// ----------------------------------------------------------------------------
// An item is accepted only while the sequencer is idle, so the next item waits
// until the division, the state update and any renormalization word are done.
// The division is done by a radix-2 restoring divider, which produces one
// quotient bit per cycle, followed by a step that assembles the new coder
// state. A flush item emits the low word and then the high word of the coder
// state; the consumer reads the words in reverse order.
// Results pass through an output register, so a waiting result stalls the
// block only when a new result has to be written into that register.
module binary_rans_context_encoder_unit #(
  parameter int PREC_BITS = brce_pkg::PREC_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic        in_bit_req,
  input  logic        in_context_bit,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_word,
  output logic        out_last
);

  localparam int QW    = brce_pkg::STATE_BITS - PREC_BITS;
  localparam int CNT_W = $clog2(QW);
  localparam logic [16:0] PROB_ONE = 17'(1) << PREC_BITS;
  localparam logic [PREC_BITS-1:0] P0_CEIL  = {PREC_BITS{1'b1}};
  localparam logic [PREC_BITS-1:0] P0_FLOOR = PREC_BITS'(1);

  // Registers
  brce_pkg::seq_state_t state_r, state_nxt;
  logic [brce_pkg::STATE_BITS-1:0] coder_state_r;
  logic [15:0]                     prob_zero_r;
  logic [PREC_BITS-1:0]            freq_r;
  logic [PREC_BITS-1:0]            cdf_r;
  logic [PREC_BITS-1:0]            rem_r;
  logic [QW-1:0]                   dvd_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            renorm_r;
  logic [15:0]                     word_r;
  logic                            out_valid_r;
  logic [15:0]                     out_word_r;
  logic                            out_last_r;

  // Control strobes from the sequencer
  logic start_c;
  logic div_c;
  logic fin_c;
  logic emit_c;
  logic flush_lo_c;
  logic flush_hi_c;
  logic slot_free;

  // Accept-time datapath
  logic [PREC_BITS-1:0]            p0_clamp;
  logic [PREC_BITS-1:0]            p0_ctx;
  logic [PREC_BITS-1:0]            freq_c;
  logic [PREC_BITS-1:0]            cdf_c;
  logic                            renorm_c;
  logic [brce_pkg::STATE_BITS-1:0] st_eff;

  // Divider step datapath
  logic [PREC_BITS:0]              trial;
  logic [PREC_BITS:0]              diff;
  logic                            q_bit;
  logic [PREC_BITS-1:0]            rem_step;
  logic [brce_pkg::STATE_BITS-1:0] new_state;

  // Output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_ready;

  // Clamp the probability into [1, 2^PREC_BITS - 1], apply the context and pick freq and cdf.
  always_comb begin
    priority if (prob_zero_r == 16'd0) begin
      p0_clamp = P0_FLOOR;
    end else if ({1'b0, prob_zero_r} >= PROB_ONE) begin
      p0_clamp = P0_CEIL;
    end else begin
      p0_clamp = prob_zero_r[PREC_BITS-1:0];
    end
    // 2^PREC_BITS minus a value in range is its negation at this width.
    p0_ctx = in_context_bit ? (PREC_BITS'(0) - p0_clamp) : p0_clamp;
    freq_c = in_bit_req ? (PREC_BITS'(0) - p0_ctx) : p0_ctx;
    cdf_c  = in_bit_req ? p0_ctx : PREC_BITS'(0);
  end

  // Renormalize when the state is at or above freq shifted up by QW bits.
  always_comb begin
    renorm_c = ({{(16 - PREC_BITS + 1){1'b0}}, coder_state_r[brce_pkg::STATE_BITS-1:QW]}
                >= {{(16 - PREC_BITS + 1){1'b0}}, freq_c});
    st_eff   = renorm_c ? {16'd0, coder_state_r[31:16]} : coder_state_r;
  end

  // One restoring division step per cycle.
  always_comb begin
    trial    = {rem_r, dvd_r[QW-1]};
    diff     = trial - {1'b0, freq_r};
    q_bit    = !diff[PREC_BITS];
    rem_step = q_bit ? diff[PREC_BITS-1:0] : trial[PREC_BITS-1:0];
  end

  // New state: quotient shifted up, plus the cumulative frequency and remainder.
  assign new_state = {dvd_r, {PREC_BITS{1'b0}}}
                   + brce_pkg::STATE_BITS'(cdf_r)
                   + brce_pkg::STATE_BITS'(rem_r);

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brce_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_operation == brce_pkg::OP_FLUSH) ? brce_pkg::ST_FLUSH_LO
                                                           : brce_pkg::ST_DIV;
        end
      end
      brce_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = brce_pkg::ST_FIN;
        end
      end
      brce_pkg::ST_FIN: begin
        state_nxt = renorm_r ? brce_pkg::ST_EMIT : brce_pkg::ST_IDLE;
      end
      brce_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_nxt = brce_pkg::ST_IDLE;
        end
      end
      brce_pkg::ST_FLUSH_LO: begin
        if (slot_free) begin
          state_nxt = brce_pkg::ST_FLUSH_HI;
        end
      end
      brce_pkg::ST_FLUSH_HI: begin
        if (slot_free) begin
          state_nxt = brce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = brce_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    div_c      = 1'b0;
    fin_c      = 1'b0;
    emit_c     = 1'b0;
    flush_lo_c = 1'b0;
    flush_hi_c = 1'b0;
    unique case (state_r)
      brce_pkg::ST_IDLE:     in_ready   = 1'b1;
      brce_pkg::ST_DIV:      div_c      = 1'b1;
      brce_pkg::ST_FIN:      fin_c      = 1'b1;
      brce_pkg::ST_EMIT:     emit_c     = slot_free;
      brce_pkg::ST_FLUSH_LO: flush_lo_c = slot_free;
      brce_pkg::ST_FLUSH_HI: flush_hi_c = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
    start_c = in_ready && in_valid && (in_operation == brce_pkg::OP_ENCODE);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= brce_pkg::ST_IDLE;
      coder_state_r <= brce_pkg::STATE_RESET;
      prob_zero_r   <= brce_pkg::PROB_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        prob_zero_r <= cfg_wr_data;
      end
      if (fin_c) begin
        coder_state_r <= new_state;
      end else if (flush_hi_c) begin
        coder_state_r <= brce_pkg::STATE_RESET;
      end
      if (emit_c || flush_lo_c || flush_hi_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Divider and payload registers.
  always_ff @(posedge clk) begin
    if (start_c) begin
      freq_r   <= freq_c;
      cdf_r    <= cdf_c;
      renorm_r <= renorm_c;
      word_r   <= coder_state_r[15:0];
      rem_r    <= st_eff[brce_pkg::STATE_BITS-1:QW];
      dvd_r    <= st_eff[QW-1:0];
      cnt_r    <= CNT_W'(QW - 1);
    end else if (div_c) begin
      rem_r <= rem_step;
      dvd_r <= {dvd_r[QW-2:0], q_bit};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (emit_c) begin
      out_word_r <= word_r;
      out_last_r <= 1'b1;
    end else if (flush_lo_c) begin
      out_word_r <= coder_state_r[15:0];
      out_last_r <= 1'b0;
    end else if (flush_hi_c) begin
      out_word_r <= coder_state_r[31:16];
      out_last_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  // The partial remainder stays below the divisor throughout the division.
  a_rem_below_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == brce_pkg::ST_DIV) |-> (rem_r < freq_r))
    else $error("divider remainder not below frequency");

  // An accepted flush item goes straight to emitting the low word.
  a_flush_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_operation == brce_pkg::OP_FLUSH))
      |=> (state_r == brce_pkg::ST_FLUSH_LO))
    else $error("flush item did not start the flush sequence");

  // Writing the high flush word restarts the coder.
  a_flush_restart: assert property (@(posedge clk) disable iff (!rst_n)
    flush_hi_c |=> (coder_state_r == brce_pkg::STATE_RESET) && out_valid && out_last)
    else $error("flush did not restart the coder state");
`endif

endmodule

// ===== tb/tb_binary_rans_context_encoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_rans_context_encoder_unit: self-checking bench of the rANS encoder
// A table of directed items covers reset, flushes and the probability extremes.
// Random phases under several probability settings follow. Every code word is
// checked against the bench's behavioral coder model or a word typed in the table.
// ----------------------------------------------------------------------------
module tb_binary_rans_context_encoder_unit;

  localparam int          PB            = brce_pkg::PREC_BITS_DEFAULT;
  localparam logic [63:0] PROB_ONE      = 64'd1 << PB;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASES        = 8;
  localparam int          PHASE_ITEMS   = 236;
  localparam int          DIR_ROWS      = 23;
  localparam int          TIMEOUT_NS    = 12_000_000;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } code_word_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table; n_typed < 0 means the model supplies it.
  typedef struct {
    row_kind_t   kind;
    logic        op;
    logic        bit_val;
    logic        ctx;
    logic [15:0] prob;
    int          n_typed;
    code_word_t  typed_lo;
    code_word_t  typed_hi;
  } stim_row_t;

  localparam code_word_t NO_WORD = '0;
  localparam code_word_t LO_ZERO = '{16'h0000, 1'b0};
  localparam code_word_t HI_ONE  = '{16'h0001, 1'b1};
  localparam code_word_t RENORM0 = '{16'h0000, 1'b1};

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_wr_en      = 1'b0;
  logic [15:0] cfg_wr_data    = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic        in_operation   = brce_pkg::OP_ENCODE;
  logic        in_bit_req     = 1'b0;
  logic        in_context_bit = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [15:0] out_word;
  logic        out_last;

  // Model copy of the coder and the register, and the words still to come.
  logic [31:0] model_state   = brce_pkg::STATE_RESET;
  logic [15:0] model_prob    = brce_pkg::PROB_RESET;
  code_word_t  code_words[$];
  int          fail_count    = 0;
  bit          hold_req      = 1'b0;
  bit          steady_sender = 1'b0;

  binary_rans_context_encoder_unit #(
    .PREC_BITS(PB)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_bit_req    (in_bit_req),
    .in_context_bit(in_context_bit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word      (out_word),
    .out_last      (out_last)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advances the model coder by one item and returns the words it emits.
  function automatic int rans_encode_step(input logic op, input logic bit_val,
                                          input logic ctx, output code_word_t lo,
                                          output code_word_t hi);
    logic [63:0] st;
    logic [63:0] p0;
    logic [63:0] freq;
    logic [63:0] cdf;
    int          n;
    st = {32'd0, model_state};
    n  = 0;
    lo = NO_WORD;
    hi = NO_WORD;
    if (op == brce_pkg::OP_FLUSH) begin
      lo = '{st[15:0], 1'b0};
      hi = '{st[31:16], 1'b1};
      model_state = brce_pkg::STATE_RESET;
      return 2;
    end
    // Clamp the probability into the usable range, then apply the context.
    p0 = {48'd0, model_prob};
    if (p0 == 0) p0 = 64'd1;
    else if (p0 >= PROB_ONE) p0 = PROB_ONE - 1;
    if (ctx) p0 = PROB_ONE - p0;
    if (bit_val) begin
      freq = PROB_ONE - p0;
      cdf  = p0;
    end else begin
      freq = p0;
      cdf  = '0;
    end
    // Renormalize before the update when the state would overflow.
    if (st >= (freq << (32 - PB))) begin
      lo = '{st[15:0], 1'b1};
      n  = 1;
      st = st >> brce_pkg::WORD_BITS;
    end
    st = ((st / freq) << PB) + cdf + (st % freq);
    model_state = st[31:0];
    return n;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item, waits for acceptance, records its words, then may idle.
  task automatic send_item(input logic op, input logic bit_val, input logic ctx,
                           input int n_typed, input code_word_t t_lo,
                           input code_word_t t_hi);
    code_word_t lo;
    code_word_t hi;
    int         n;
    int         gap;
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_bit_req     <= bit_val;
    in_context_bit <= ctx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = rans_encode_step(op, bit_val, ctx, lo, hi);
    if (n_typed >= 0) begin
      n  = n_typed;
      lo = t_lo;
      hi = t_hi;
    end
    if (n >= 1) code_words.push_back(lo);
    if (n == 2) code_words.push_back(hi);
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every word is in and the coder is idle.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (code_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the probability register while the block is idle.
  task automatic write_prob(input logic [15:0] value);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    model_prob = value;
  endtask

  // Stimulus: directed table first, then random phases.
  initial begin
    stim_row_t   dir_tab [DIR_ROWS];
    logic [15:0] phase_prob [PHASES];
    int          bias;
    logic        op;
    logic        bit_val;
    logic        ctx;

    // After reset the state is 65536, so a flush gives words 0 and 1.
    dir_tab[0]  = '{ROW_ITEM, brce_pkg::OP_FLUSH, 1'b0, 1'b0, 16'h0, 2, LO_ZERO, HI_ONE};
    // A flush ignores its bits and restarts the coder.
    dir_tab[1]  = '{ROW_ITEM, brce_pkg::OP_FLUSH, 1'b1, 1'b1, 16'h0, 2, LO_ZERO, HI_ONE};
    dir_tab[2]  = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b0, 1'b0, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[3]  = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b1, 1'b0, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[4]  = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b0, 1'b1, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[5]  = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b1, 1'b1, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[6]  = '{ROW_ITEM, brce_pkg::OP_FLUSH, 1'b0, 1'b1, 16'h0, -1, NO_WORD, NO_WORD};
    // A zero probability acts as one; a zero bit from the reset state then
    // renormalizes out a zero word and leaves the state at 65536.
    dir_tab[7]  = '{ROW_CFG, brce_pkg::OP_ENCODE, 1'b0, 1'b0, 16'h0000, -1, NO_WORD, NO_WORD};
    dir_tab[8]  = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b0, 1'b0, 16'h0, 1, RENORM0, NO_WORD};
    dir_tab[9]  = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b0, 1'b0, 16'h0, 1, RENORM0, NO_WORD};
    dir_tab[10] = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b1, 1'b0, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[11] = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b1, 1'b1, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[12] = '{ROW_ITEM, brce_pkg::OP_FLUSH, 1'b1, 1'b0, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[13] = '{ROW_CFG, brce_pkg::OP_ENCODE, 1'b0, 1'b0, 16'h0001, -1, NO_WORD, NO_WORD};
    dir_tab[14] = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b0, 1'b0, 16'h0, 1, RENORM0, NO_WORD};
    dir_tab[15] = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b0, 1'b1, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[16] = '{ROW_ITEM, brce_pkg::OP_FLUSH, 1'b0, 1'b0, 16'h0, -1, NO_WORD, NO_WORD};
    // Largest probability: a one bit gets the smallest frequency.
    dir_tab[17] = '{ROW_CFG, brce_pkg::OP_ENCODE, 1'b0, 1'b0, 16'hFFFF, -1, NO_WORD, NO_WORD};
    dir_tab[18] = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b0, 1'b0, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[19] = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b1, 1'b0, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[20] = '{ROW_ITEM, brce_pkg::OP_ENCODE, 1'b1, 1'b1, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[21] = '{ROW_ITEM, brce_pkg::OP_FLUSH, 1'b0, 1'b0, 16'h0, -1, NO_WORD, NO_WORD};
    dir_tab[22] = '{ROW_CFG, brce_pkg::OP_ENCODE, 1'b0, 1'b0, brce_pkg::PROB_RESET, -1,
                    NO_WORD, NO_WORD};

    phase_prob[0] = 16'h0000;
    phase_prob[1] = 16'h0001;
    phase_prob[2] = 16'hFFFF;
    phase_prob[3] = brce_pkg::PROB_RESET;
    phase_prob[4] = 16'($urandom_range(0, 65535));
    phase_prob[5] = 16'($urandom_range(1, 255));
    phase_prob[6] = 16'($urandom_range(65280, 65535));
    phase_prob[7] = 16'($urandom_range(0, 65535));

    // Hold the synchronous reset, then release it.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) begin
        write_prob(dir_tab[r].prob);
      end else begin
        send_item(dir_tab[r].op, dir_tab[r].bit_val, dir_tab[r].ctx,
                  dir_tab[r].n_typed, dir_tab[r].typed_lo, dir_tab[r].typed_hi);
      end
    end

    // Random phases: long runs of encodes with occasional flushes, each phase
    // closed by a flush so the stream ends cleanly.
    for (int p = 0; p < PHASES; p++) begin
      write_prob(phase_prob[p]);
      bias          = $urandom_range(5, 95);
      steady_sender = (p == 5);
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op      = ($urandom_range(0, 24) == 0) ? brce_pkg::OP_FLUSH : brce_pkg::OP_ENCODE;
        ctx     = 1'($urandom_range(0, 1));
        bit_val = ($urandom_range(0, 99) < bias) ? ~ctx : ctx;
        send_item(op, bit_val, ctx, -1, NO_WORD, NO_WORD);
      end
      send_item(brce_pkg::OP_FLUSH, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                -1, NO_WORD, NO_WORD);
    end
    steady_sender = 1'b0;

    settle_block();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stalls, quiet stretches, and one long hold-off.
  initial begin
    int on_len;
    int off_len;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= 1'b1;
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                           : $urandom_range(1, 8);
      repeat (on_len) @(posedge clk);
      off_len = pick_gap();
      if (off_len > 0) begin
        out_ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  // Compare each accepted word with the oldest expected one.
  always @(posedge clk) begin
    code_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (code_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h last %b",
                 $time, out_word, out_last);
        fail_count++;
      end else begin
        want = code_words.pop_front();
        if (out_word !== want.value) begin
          $display("%0t: word mismatch: expected %h, actual %h",
                   $time, want.value, out_word);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/brce_pkg.sv
rtl/binary_rans_context_encoder_unit.sv
tb/tb_binary_rans_context_encoder_unit.sv
